### rtl/supply_voltage_supervisor_macros.svh
// ----------------------------------------------------------------------------
// Supply voltage supervisor assertion macros
// Shorthand for the clocked, reset-gated assertions of the supervisor.
// ----------------------------------------------------------------------------
`ifndef SUPPLY_VOLTAGE_SUPERVISOR_MACROS_SVH
`define SUPPLY_VOLTAGE_SUPERVISOR_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define SVS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define SVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/svs_pkg.sv
// ----------------------------------------------------------------------------
// Supply voltage supervisor package
// Widths, register indexes, reset values and alarm codes.
// ----------------------------------------------------------------------------
package svs_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int TIME_BITS   = 32;
  localparam int HOLD_BITS   = 16;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 3;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [TIME_BITS-1:0]   stamp_t;
  typedef logic [HOLD_BITS-1:0]   hold_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FUSE_LEVEL  = 3'd0,
    CFG_MIN_LEVEL   = 3'd1,
    CFG_LOW_LEVEL   = 3'd2,
    CFG_MAX_LEVEL   = 3'd3,
    CFG_HOLD_TIME   = 3'd4,
    CFG_ALARM_DIS   = 3'd5
  } cfg_idx_t;

  // Reset values
  localparam sample_t FUSE_LEVEL_RST = sample_t'(300);
  localparam sample_t MIN_LEVEL_RST  = sample_t'(600);
  localparam sample_t LOW_LEVEL_RST  = sample_t'(650);
  localparam sample_t MAX_LEVEL_RST  = sample_t'(900);
  localparam hold_t   HOLD_TIME_RST  = hold_t'(1000);

  // Alarm choice codes
  typedef logic [1:0] alarm_t;
  localparam alarm_t ALARM_NONE  = 2'd0;
  localparam alarm_t ALARM_OVER  = 2'd1;
  localparam alarm_t ALARM_FUSE  = 2'd2;
  localparam alarm_t ALARM_UNDER = 2'd3;

  // Latched fault set
  typedef struct packed {
    logic fuse;
    logic under;
    logic over;
  } fault_t;

endpackage

### rtl/svs_if.sv
// ----------------------------------------------------------------------------
// Supply voltage supervisor channels
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------

// Sample channel
interface svs_in_if import svs_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t supply_sample;
  stamp_t  time_now;
  logic    alarm_busy;

  modport source (output valid, output supply_sample, output time_now,
                  output alarm_busy, input ready);
  modport sink   (input valid, input supply_sample, input time_now,
                  input alarm_busy, output ready);
endinterface

// Result channel
interface svs_out_if import svs_pkg::*;;
  logic    valid;
  logic    ready;
  logic    fault_overvoltage;
  logic    fault_undervoltage;
  logic    fault_fuse;
  sample_t lowest_sample;
  sample_t highest_sample;
  logic    drive_stop;
  alarm_t  alarm_select;

  modport source (output valid, output fault_overvoltage, output fault_undervoltage,
                  output fault_fuse, output lowest_sample, output highest_sample,
                  output drive_stop, output alarm_select, input ready);
  modport sink   (input valid, input fault_overvoltage, input fault_undervoltage,
                  input fault_fuse, input lowest_sample, input highest_sample,
                  input drive_stop, input alarm_select, output ready);
endinterface

### rtl/supply_voltage_supervisor.sv
// An accepted sample item passes the input register, then the result register, to its result item.
// Throughput: one item per cycle; the input register refills while the
// result register is taken, so only a stalled result holds the input back.
// Reset (rst_n low, synchronous): levels and hold time to defaults, faults,
// good stamp and min/max tracking cleared, both stages emptied.
// ----------------------------------------------------------------------------
// Supply voltage supervisor
// Latches fuse, undervoltage and overvoltage faults from battery samples,
// tracks min/max samples and picks a prioritized alarm.
// ----------------------------------------------------------------------------
`include "supply_voltage_supervisor_macros.svh"

module supply_voltage_supervisor import svs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_wdata,
  svs_in_if.sink                  in_ch,
  svs_out_if.source               out_ch
);

  // Configuration registers
  sample_t fuse_level_r, min_level_r, low_level_r, max_level_r;
  hold_t   hold_time_r;
  logic    alarm_dis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fuse_level_r <= FUSE_LEVEL_RST;
      min_level_r  <= MIN_LEVEL_RST;
      low_level_r  <= LOW_LEVEL_RST;
      max_level_r  <= MAX_LEVEL_RST;
      hold_time_r  <= HOLD_TIME_RST;
      alarm_dis_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FUSE_LEVEL: fuse_level_r <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_MIN_LEVEL:  min_level_r  <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_LOW_LEVEL:  low_level_r  <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_MAX_LEVEL:  max_level_r  <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_HOLD_TIME:  hold_time_r  <= cfg_wdata[HOLD_BITS-1:0];
        CFG_ALARM_DIS:  alarm_dis_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register stage
  logic    in_valid_r;
  sample_t sample_r;
  stamp_t  now_r;
  logic    busy_r;
  logic    out_valid_r;
  logic    advance;

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      sample_r <= in_ch.supply_sample;
      now_r    <= in_ch.time_now;
      busy_r   <= in_ch.alarm_busy;
    end
  end

  // Supervisor state
  stamp_t  good_stamp_r, good_stamp_nxt;
  fault_t  fault_r, fault_nxt;
  sample_t min_seen_r, min_seen_nxt;
  sample_t max_seen_r, max_seen_nxt;
  alarm_t  alarm_nxt;
  logic    held_long;
  stamp_t  elapsed;

  // Time since the last good sample, modulo the stamp width
  assign elapsed   = now_r - good_stamp_r;
  assign held_long = elapsed >= stamp_t'(hold_time_r);

  // Fault latching, good stamp refresh and min/max tracking
  always_comb begin
    good_stamp_nxt = good_stamp_r;
    fault_nxt      = fault_r;
    min_seen_nxt   = min_seen_r;
    max_seen_nxt   = max_seen_r;
    if (sample_r < fuse_level_r) begin
      if (held_long) fault_nxt.fuse = 1'b1;
    end else if (sample_r < min_level_r) begin
      if (held_long) fault_nxt.under = 1'b1;
    end else begin
      if (sample_r > low_level_r) good_stamp_nxt = now_r;
      if (sample_r > max_level_r) fault_nxt.over = 1'b1;
    end
    // zero max means no sample yet: first sample loads both
    if (max_seen_r == '0) begin
      min_seen_nxt = sample_r;
      max_seen_nxt = sample_r;
    end else begin
      if (sample_r < min_seen_r) min_seen_nxt = sample_r;
      if (sample_r > max_seen_r) max_seen_nxt = sample_r;
    end
  end

  // Alarm priority: overvoltage, fuse, undervoltage; pending low also counts
  // as undervoltage (a refreshed stamp implies sample above low level)
  always_comb begin
    alarm_nxt = ALARM_NONE;
    if (!busy_r && !alarm_dis_r) begin
      if (fault_nxt.over) begin
        alarm_nxt = ALARM_OVER;
      end else if (fault_nxt.fuse) begin
        alarm_nxt = ALARM_FUSE;
      end else if (fault_nxt.under || (sample_r <= low_level_r && held_long)) begin
        alarm_nxt = ALARM_UNDER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_stamp_r <= '0;
      fault_r      <= '0;
      min_seen_r   <= '0;
      max_seen_r   <= '0;
    end else if (advance) begin
      good_stamp_r <= good_stamp_nxt;
      fault_r      <= fault_nxt;
      min_seen_r   <= min_seen_nxt;
      max_seen_r   <= max_seen_nxt;
    end
  end

  // Result register stage
  alarm_t alarm_r;
  logic   drive_stop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      alarm_r      <= alarm_nxt;
      drive_stop_r <= |fault_nxt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.fault_overvoltage  = fault_r.over;
  assign out_ch.fault_undervoltage = fault_r.under;
  assign out_ch.fault_fuse         = fault_r.fuse;
  assign out_ch.lowest_sample      = min_seen_r;
  assign out_ch.highest_sample     = max_seen_r;
  assign out_ch.drive_stop         = drive_stop_r;
  assign out_ch.alarm_select       = alarm_r;

  // Checks
  `SVS_ASSERT_NEXT(a_fault_sticky, 1'b1, (fault_r | $past(fault_r)) == fault_r,
    "latched fault cleared without reset")
  `SVS_ASSERT_NOW(a_min_le_max, max_seen_r != '0, min_seen_r <= max_seen_r,
    "lowest sample above highest sample")
  `SVS_ASSERT_NEXT(a_in_hold, in_valid_r && out_valid_r && !out_ch.ready,
    in_valid_r && $stable(sample_r) && $stable(now_r),
    "pending sample item dropped during result stall")

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Supply voltage supervisor testbench
// Sends battery sample items with time stamps and busy flags, predicts each
// report item from a cycle-free model of the fault latches, min/max tracking
// and alarm choice, and checks every report in order. Directed tests cover
// reset values, the first-sample rule, hold-window edges and each fault;
// random sections sweep levels, hold times, idling and back pressure.
// ----------------------------------------------------------------------------
module tb import svs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected report item, in port order
  typedef struct packed {
    logic    over;
    logic    under;
    logic    fuse;
    sample_t lowest;
    sample_t highest;
    logic    stop;
    alarm_t  alarm;
  } report_t;

  // Indexes past the last register; writes there must change nothing
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;
  localparam int SAMPLE_TOP  = (1 << SAMPLE_BITS) - 1;
  localparam int PIPE_CYCLES = 2;
  localparam int MAX_SHOWN   = 10;
  localparam int LONG_STALL  = 200;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_wdata;

  svs_in_if  in_ch ();
  svs_out_if out_ch ();

  supply_voltage_supervisor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Model copy of the registers and state
  sample_t fuse_lvl, min_lvl, low_lvl, max_lvl;
  hold_t   hold_ticks;
  logic    alarm_off;
  stamp_t  last_good;
  fault_t  latched;
  sample_t lowest_seen, highest_seen;

  report_t expected_reports[$];
  stamp_t  tick;
  bit      in_idle, out_idle;
  int      hold_off_cycles;
  int      samples_sent, reports_checked, writes_done, mismatches;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Has the supply been low for at least the hold time (modular age)?
  function automatic logic held_long_enough(stamp_t now);
    stamp_t age;
    age = now - last_good;
    return age >= stamp_t'(hold_ticks);
  endfunction

  // One sample through the supervisor: update state, return the report
  function automatic report_t supervise_sample(sample_t s, stamp_t now, logic busy);
    report_t r;
    if (s < fuse_lvl) begin
      if (held_long_enough(now)) latched.fuse = 1'b1;
    end else if (s < min_lvl) begin
      if (held_long_enough(now)) latched.under = 1'b1;
    end else begin
      if (s > low_lvl) last_good = now;
      if (s > max_lvl) latched.over = 1'b1;
    end
    // zero max means no sample yet, so a zero sample keeps reloading both
    if (highest_seen == '0) begin
      lowest_seen  = s;
      highest_seen = s;
    end else begin
      if (s < lowest_seen)  lowest_seen  = s;
      if (s > highest_seen) highest_seen = s;
    end
    r.over    = latched.over;
    r.under   = latched.under;
    r.fuse    = latched.fuse;
    r.lowest  = lowest_seen;
    r.highest = highest_seen;
    r.stop    = |latched;
    r.alarm   = ALARM_NONE;
    if (!busy && !alarm_off) begin
      if (latched.over)
        r.alarm = ALARM_OVER;
      else if (latched.fuse)
        r.alarm = ALARM_FUSE;
      else if (latched.under || (s <= low_lvl && held_long_enough(now)))
        r.alarm = ALARM_UNDER;
    end
    return r;
  endfunction

  // Register write; only called while nothing is in flight
  task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FUSE_LEVEL: fuse_lvl   = value[SAMPLE_BITS-1:0];
      CFG_MIN_LEVEL:  min_lvl    = value[SAMPLE_BITS-1:0];
      CFG_LOW_LEVEL:  low_lvl    = value[SAMPLE_BITS-1:0];
      CFG_MAX_LEVEL:  max_lvl    = value[SAMPLE_BITS-1:0];
      CFG_HOLD_TIME:  hold_ticks = value[HOLD_BITS-1:0];
      CFG_ALARM_DIS:  alarm_off  = value[0];
      default: ;
    endcase
    writes_done++;
  endtask

  // All six registers; junk in the unused upper data bits
  task automatic load_thresholds(sample_t fuse, sample_t min, sample_t low, sample_t max,
                                 hold_t hold, logic dis);
    write_register(CFG_FUSE_LEVEL, {6'($urandom), fuse});
    write_register(CFG_MIN_LEVEL,  {6'($urandom), min});
    write_register(CFG_LOW_LEVEL,  {6'($urandom), low});
    write_register(CFG_MAX_LEVEL,  {6'($urandom), max});
    write_register(CFG_HOLD_TIME,  hold);
    write_register(CFG_ALARM_DIS,  {15'($urandom), dis});
  endtask

  // Offer one sample item and record its report once accepted
  task automatic send_sample(sample_t s, stamp_t now, logic busy);
    int gap;
    gap = in_idle ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.supply_sample <= s;
    in_ch.time_now      <= now;
    in_ch.alarm_busy    <= busy;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_reports.push_back(supervise_sample(s, now, busy));
    samples_sent++;
  endtask

  // Random sample clustered around the current levels; time mostly creeps
  // forward at the scale of the hold time, with the odd wild jump
  task automatic send_random_sample();
    int lvl;
    case ($urandom_range(0, 7))
      0, 1:    lvl = $urandom_range(0, SAMPLE_TOP);
      2:       lvl = fuse_lvl;
      3:       lvl = min_lvl;
      4, 5:    lvl = low_lvl;
      6:       lvl = max_lvl;
      default: lvl = $urandom_range(0, 1) ? SAMPLE_TOP : 0;
    endcase
    lvl += int'($urandom_range(0, 4)) - 2;
    if (lvl < 0) lvl = 0;
    if (lvl > SAMPLE_TOP) lvl = SAMPLE_TOP;
    if ($urandom_range(0, 15) == 0)
      tick = $urandom;
    else
      tick += $urandom_range(0, int'(hold_ticks) / 4 + 3);
    send_sample(sample_t'(lvl), tick, $urandom_range(0, 3) == 0);
  endtask

  // Stop offering and wait for every outstanding report
  task automatic wait_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES + 2) @(posedge clk);
  endtask

  // Receiver: random stall per item, or one long hold-off when asked
  initial begin : report_taker
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      gap = out_idle ? $urandom_range(0, 11) : 0;
      if (hold_off_cycles > 0) begin
        gap = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // Report checker
  always @(posedge clk) begin : check_reports
    report_t got, want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.fault_overvoltage, out_ch.fault_undervoltage, out_ch.fault_fuse,
             out_ch.lowest_sample, out_ch.highest_sample, out_ch.drive_stop,
             out_ch.alarm_select};
      reports_checked++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("%0t: report item with nothing expected", $time);
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("%0t: report mismatch (ov uv fuse lo hi stop alarm)", $time);
            $display("  expected %b %b %b %0d %0d %b %0d", want.over, want.under,
                     want.fuse, want.lowest, want.highest, want.stop, want.alarm);
            $display("  actual   %b %b %b %0d %0d %b %0d", got.over, got.under,
                     got.fuse, got.lowest, got.highest, got.stop, got.alarm);
          end
        end
      end
    end
  end

  // Reset levels, first-sample rule, hold window edge and tick wrap
  task automatic test_reset_values_and_first_sample();
    send_sample(0, 0, 1'b0);             // zero sample: still no sample recorded
    send_sample(0, 1, 1'b1);
    send_sample(450, 2, 1'b0);           // loads both min and max
    send_sample(620, 3, 1'b1);
    send_sample(700, 10, 1'b0);          // above low level: refresh good time
    send_sample(640, 1009, 1'b0);        // one tick short of the hold time
    send_sample(640, 1010, 1'b0);        // hold reached: undervoltage alarm only
    send_sample(650, 1011, 1'b0);        // at low level: no refresh
    send_sample(651, '1, 1'b0);          // refresh at the top of the tick range
    send_sample(640, 5, 1'b0);           // age wraps through zero
    wait_until_drained();
    tick = 5;
  endtask

  // No fault can latch here (fuse and min at zero, max at top); sweeps the
  // low level and hold time, including both extremes, under mixed idling
  task automatic test_hold_window_sweep();
    hold_t   hold;
    sample_t low;
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0:       begin hold = '0; low = '0; end
        1:       begin hold = '1; low = sample_t'(SAMPLE_TOP); end
        2:       begin hold = 1;  low = sample_t'($urandom_range(0, SAMPLE_TOP)); end
        default: begin
          hold = hold_t'($urandom_range(2, 5000));
          low  = sample_t'($urandom_range(0, SAMPLE_TOP));
        end
      endcase
      load_thresholds('0, '0, low, sample_t'(SAMPLE_TOP), hold, seg == 3);
      in_idle  = seg[0];
      out_idle = seg[1] | seg[2];
      repeat (70) send_random_sample();
      wait_until_drained();
    end
    in_idle  = 1'b1;
    out_idle = 1'b1;
  endtask

  // Writes to indexes past the last register are ignored
  task automatic test_spare_register_index();
    write_register(CFG_SPARE_LO, '1);
    write_register(CFG_SPARE_HI, '0);
    repeat (10) send_random_sample();
    wait_until_drained();
  endtask

  // Long receiver stall fills the block, then a pause for a full drain
  task automatic test_back_pressure();
    in_idle  = 1'b0;
    out_idle = 1'b0;
    hold_off_cycles = LONG_STALL;
    repeat (30) send_random_sample();
    wait_until_drained();
    in_idle  = 1'b1;
    out_idle = 1'b1;
    repeat (10) send_random_sample();
    wait_until_drained();
    repeat (10) send_random_sample();
    wait_until_drained();
  endtask

  // Undervoltage latches only once the hold time has passed
  task automatic test_undervoltage_latch();
    load_thresholds(FUSE_LEVEL_RST, MIN_LEVEL_RST, LOW_LEVEL_RST, sample_t'(SAMPLE_TOP),
                    HOLD_TIME_RST, 1'b0);
    tick = 32'h8000_0000;
    send_sample(700, tick, 1'b0);
    send_sample(500, tick + 999, 1'b0);  // below min, inside the window
    send_sample(640, tick + 1000, 1'b0); // pending alarm, nothing latched
    send_sample(640, tick + 1000, 1'b1); // busy silences the alarm
    send_sample(500, tick + 1000, 1'b0); // latches undervoltage
    send_sample(800, tick + 1001, 1'b0); // stays latched
    wait_until_drained();
  endtask

  // Fuse fault takes priority over undervoltage in the alarm
  task automatic test_fuse_latch();
    tick += 5000;
    send_sample(700, tick, 1'b0);
    send_sample(0, tick + 5, 1'b0);      // below fuse level, inside the window
    send_sample(299, tick + 1000, 1'b0); // latches fuse
    send_sample(300, tick + 1001, 1'b0); // at fuse level: undervoltage path
    send_sample(680, tick + 1002, 1'b1);
    wait_until_drained();
  endtask

  // Overvoltage outranks everything; busy and disable both mute the alarm
  task automatic test_overvoltage_latch();
    write_register(CFG_MAX_LEVEL, {6'($urandom), MAX_LEVEL_RST});
    tick += 10;
    send_sample(900, tick, 1'b0);        // at max level: no fault
    send_sample(901, tick + 1, 1'b0);    // latches overvoltage
    send_sample(sample_t'(SAMPLE_TOP), tick + 2, 1'b1);
    wait_until_drained();
    write_register(CFG_ALARM_DIS, 16'h0001);
    send_sample(700, tick + 3, 1'b0);
    send_sample(sample_t'(SAMPLE_TOP), tick + 4, 1'b0);
    wait_until_drained();
    write_register(CFG_ALARM_DIS, 16'h0000);
    send_sample(0, tick + 5, 1'b0);
    wait_until_drained();
  endtask

  // Fully random levels and hold time once the faults have latched
  task automatic test_random_settings();
    for (int seg = 0; seg < 2; seg++) begin
      load_thresholds(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom),
                      sample_t'($urandom), hold_t'($urandom), $urandom_range(0, 3) == 0);
      in_idle  = seg == 0;
      out_idle = 1'b1;
      repeat (130) send_random_sample();
      wait_until_drained();
    end
  endtask

  // Test sequence
  initial begin : stimulus
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.supply_sample = '0;
    in_ch.time_now      = '0;
    in_ch.alarm_busy    = 1'b0;
    in_idle             = 1'b1;
    out_idle            = 1'b1;
    hold_off_cycles     = 0;
    tick                = '0;
    samples_sent        = 0;
    reports_checked     = 0;
    writes_done         = 0;
    mismatches          = 0;
    fuse_lvl            = FUSE_LEVEL_RST;
    min_lvl             = MIN_LEVEL_RST;
    low_lvl             = LOW_LEVEL_RST;
    max_lvl             = MAX_LEVEL_RST;
    hold_ticks          = HOLD_TIME_RST;
    alarm_off           = 1'b0;
    last_good           = '0;
    latched             = '0;
    lowest_seen         = '0;
    highest_seen        = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values_and_first_sample();
    test_hold_window_sweep();
    test_spare_register_index();
    test_back_pressure();
    test_undervoltage_latch();
    test_fuse_latch();
    test_overvoltage_latch();
    test_random_settings();

    repeat (PIPE_CYCLES + 4) @(posedge clk);
    $display("Covered %0d sample items, %0d report items, %0d register writes:",
             samples_sent, reports_checked, writes_done);
    $display("reset levels, hold-window edges, tick wrap, all faults, alarm priority, stalls.");
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d reports outstanding", expected_reports.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/svs_pkg.sv
rtl/svs_if.sv
rtl/supply_voltage_supervisor.sv
tb/sv/tb.sv
